### rtl/rlpb_pkg.sv
package rlpb_pkg;

  localparam int RUN_BITS = 15;
  localparam int ADDR_BITS = 16;
  localparam int BYTES_BITS = RUN_BITS - 3;
  localparam int CAP_BITS = 16;
  localparam int SUM_BITS = ((ADDR_BITS > CAP_BITS) ? ADDR_BITS : CAP_BITS) + 1;
  localparam int NUM_SLOTS = 4;
  localparam int SLOT_BITS = 2;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 16'd10000;
  localparam logic [31:0] MAX_REPEAT = 32'd4095;
  localparam logic [7:0] FILL_ONES = 8'hFF;
  localparam logic [7:0] FILL_ZEROS = 8'h00;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_FILL = 2'd1,
    KIND_LINE = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [15:0] addr;
    logic [7:0] value;
    logic [11:0] rep;
    logic last;
  } res_t;

endpackage

### rtl/run_length_to_packed_bits.sv
// Run-length to packed bitmap expander.
// Input channel (in_valid/in_stall) carries one run per word: laser_on,
// run_length and end_of_line. Output channel (out_valid/out_stall) carries
// one result word per handshake: kind, byte_address, byte_value,
// repeat_count and last. The capacity register is written over its own
// channel (cfg_valid/cfg_ready, data on capacity_bytes); cfg_ready is
// always high and the register takes effect for the next run.
// A run is expanded in the cycle it is accepted; its results (zero to
// four) sit in a four-entry result bank and leave one per cycle while the
// receiver does not stall, the first shown in the cycle after acceptance.
// A run with zero or one result is taken every cycle while the receiver
// does not stall; a run with more holds the input while the single output
// port drains the bank; the next is taken in the cycle its last one leaves.
// When the receiver stalls, the current result word holds and the input
// stalls once the bank cannot be emptied in that cycle.
// Synchronous reset empties the bank, clears the partial byte, bit and
// byte positions, and sets the capacity to 10000 bytes.
module run_length_to_packed_bits (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rlpb_pkg::CAP_BITS-1:0]        capacity_bytes,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 laser_on,
  input  logic [rlpb_pkg::RUN_BITS-1:0]        run_length,
  input  logic                                 end_of_line,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           kind,
  output logic [15:0]                          byte_address,
  output logic [7:0]                           byte_value,
  output logic [11:0]                          repeat_count,
  output logic                                 last
);

  localparam int RB = rlpb_pkg::RUN_BITS;
  localparam int AB = rlpb_pkg::ADDR_BITS;
  localparam int BB = rlpb_pkg::BYTES_BITS;
  localparam int SB = rlpb_pkg::SUM_BITS;
  localparam int NS = rlpb_pkg::NUM_SLOTS;

  logic [rlpb_pkg::CAP_BITS-1:0] capacity;
  logic [7:0] partial_byte;
  logic [2:0] bit_position;
  logic [AB-1:0] byte_position;
  logic [NS-1:0] slot_valid;
  rlpb_pkg::res_t bank [NS];

  logic [7:0] partial_byte_next;
  logic [2:0] bit_position_next;
  logic [AB-1:0] byte_position_next;
  logic [NS-1:0] slot_valid_next;
  rlpb_pkg::res_t bank_next [NS];

  logic in_fire, out_fire;
  logic [rlpb_pkg::SLOT_BITS-1:0] sel;
  logic [NS-1:0] slot_left;

  logic head_act, head_full, head_over;
  logic [3:0] avail, take, bp_sum;
  logic [7:0] head_mask, pb_head;
  logic [2:0] bp_head;
  logic [AB-1:0] pos_head;
  logic [RB-1:0] d_rest;
  logic [BB-1:0] bytes;
  logic [2:0] residue;
  logic fill_act, fill_over, res_act;
  logic [7:0] pb_body;
  logic [2:0] bp_body;
  logic [AB-1:0] pos_body;
  logic flush_act, flush_over;
  logic [AB-1:0] pos_flush;

  function automatic logic [7:0] pb_head_raw(input logic on, input logic [7:0] pb,
                                             input logic [7:0] m);
    pb_head_raw = on ? (pb | m) : (pb & ~m);
  endfunction

  assign cfg_ready = 1'b1;

  always_comb begin
    sel = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (slot_valid[i]) begin
        sel = rlpb_pkg::SLOT_BITS'(i);
      end
    end
  end

  assign slot_left = slot_valid & ~(NS'(1) << sel);
  assign out_valid = |slot_valid;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = (|slot_valid) && !(out_fire && (slot_left == '0));
  assign in_fire = in_valid && !in_stall;

  assign kind = bank[sel].kind;
  assign byte_address = bank[sel].addr;
  assign byte_value = bank[sel].value;
  assign repeat_count = bank[sel].rep;
  assign last = bank[sel].last;

  always_comb begin
    head_act = (run_length != '0) && (bit_position != 3'd0);
    avail = 4'd8 - {1'b0, bit_position};
    take = (run_length < RB'(avail)) ? 4'(run_length) : avail;
    if (!head_act) begin
      take = 4'd0;
    end
    bp_sum = {1'b0, bit_position} + take;
    head_mask = (8'hFF >> bit_position) & ~(8'hFF >> bp_sum);
    head_full = head_act && (bp_sum == 4'd8);
    head_over = SB'(byte_position) >= SB'(capacity);
    pb_head = laser_on ? (partial_byte | head_mask) : (partial_byte & ~head_mask);
    bp_head = bp_sum[2:0];
    pos_head = byte_position;
    if (head_full) begin
      pb_head = 8'h00;
      bp_head = 3'd0;
      if (!head_over) begin
        pos_head = byte_position + AB'(1);
      end
    end
    d_rest = run_length - RB'(take);

    bytes = d_rest[RB-1:3];
    residue = d_rest[2:0];
    fill_act = bytes != '0;
    fill_over = ((SB'(pos_head) + SB'(bytes)) > SB'(capacity)) ||
                (32'(bytes) > rlpb_pkg::MAX_REPEAT);
    res_act = (residue != 3'd0) && !(fill_act && fill_over);
    pos_body = pos_head;
    if (fill_act && !fill_over) begin
      pos_body = AB'(SB'(pos_head) + SB'(bytes));
    end
    pb_body = pb_head;
    bp_body = bp_head;
    if (res_act) begin
      pb_body = laser_on ? 8'(8'hFF << (4'd8 - {1'b0, residue})) : 8'h00;
      bp_body = residue;
    end

    flush_act = end_of_line && (bp_body != 3'd0);
    flush_over = SB'(pos_body) >= SB'(capacity);
    pos_flush = pos_body;
    if (flush_act && !flush_over) begin
      pos_flush = pos_body + AB'(1);
    end

    if (end_of_line) begin
      partial_byte_next = 8'h00;
      bit_position_next = 3'd0;
      byte_position_next = '0;
    end else begin
      partial_byte_next = pb_body;
      bit_position_next = bp_body;
      byte_position_next = pos_body;
    end

    slot_valid_next = {end_of_line, flush_act, fill_act, head_full};

    bank_next[0].kind = head_over ? rlpb_pkg::KIND_OVERFLOW : rlpb_pkg::KIND_WRITE;
    bank_next[0].addr = 16'(byte_position);
    bank_next[0].value = head_over ? 8'h00 : pb_head_raw(laser_on, partial_byte, head_mask);
    bank_next[0].rep = head_over ? 12'd0 : 12'd1;

    bank_next[1].kind = fill_over ? rlpb_pkg::KIND_OVERFLOW : rlpb_pkg::KIND_FILL;
    bank_next[1].addr = 16'(pos_head);
    bank_next[1].value = (fill_over || !laser_on) ? rlpb_pkg::FILL_ZEROS
                                                  : rlpb_pkg::FILL_ONES;
    bank_next[1].rep = fill_over ? 12'd0 : 12'(bytes);

    bank_next[2].kind = flush_over ? rlpb_pkg::KIND_OVERFLOW : rlpb_pkg::KIND_WRITE;
    bank_next[2].addr = 16'(pos_body);
    bank_next[2].value = flush_over ? 8'h00 : pb_body;
    bank_next[2].rep = flush_over ? 12'd0 : 12'd1;

    bank_next[3].kind = rlpb_pkg::KIND_LINE;
    bank_next[3].addr = 16'(pos_flush);
    bank_next[3].value = 8'h00;
    bank_next[3].rep = 12'd0;

    for (int i = 0; i < NS; i++) begin
      bank_next[i].last = slot_valid_next[i] && ((slot_valid_next >> (i + 1)) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= rlpb_pkg::CAP_RESET;
      partial_byte <= 8'h00;
      bit_position <= 3'd0;
      byte_position <= '0;
      slot_valid <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= capacity_bytes;
      end
      if (in_fire) begin
        partial_byte <= partial_byte_next;
        bit_position <= bit_position_next;
        byte_position <= byte_position_next;
        slot_valid <= slot_valid_next;
      end else if (out_fire) begin
        slot_valid <= slot_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < NS; i++) begin
        bank[i] <= bank_next[i];
      end
    end
  end

  a_eol_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_line |=> out_valid)
    else $error("end of line accepted without a pending result");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_line |=> bit_position == 3'd0 && byte_position == '0)
    else $error("line state not cleared after end of line");

  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> $onehot(slot_valid))
    else $error("last result shown while more results pend");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    out_fire && !last |=> out_valid)
    else $error("result stream ended without last");

  a_one_hole: assert property (@(posedge clk) disable iff (rst)
    bit_position == 3'd0 |-> partial_byte == 8'h00)
    else $error("partial byte holds bits with no bit position");

endmodule
